@@ design/encoder_wrap_position_velocity_assert.svh @@
// Assertion helpers for the encoder position and velocity block.
`ifndef ENCODER_WRAP_POSITION_VELOCITY_ASSERT_SVH
`define ENCODER_WRAP_POSITION_VELOCITY_ASSERT_SVH

// same-cycle implication
`define ENCWPV_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("encwpv: check failed");

// next-cycle implication
`define ENCWPV_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("encwpv: check failed");

`endif

@@ design/encwpv_pkg.sv @@
`default_nettype none
package encwpv_pkg;

  localparam int ENCODER_BITS = 17;
  localparam int ENC_SHIFT    = 32 - ENCODER_BITS;

  localparam int FRAME_BITS   = 8;
  localparam int RAW_BITS     = 32;
  localparam int TIME_BITS    = 16;
  localparam int CALIB_BITS   = 17;
  localparam int PERIOD_BITS  = 16;
  localparam int GAIN_BITS    = 32;
  localparam int POS_BITS     = 48;
  localparam int DELTA_BITS   = 32;
  localparam int ELAPSED_BITS = 24;
  localparam int VEL_BITS     = 48;
  localparam int PROD_BITS    = 64;
  localparam int DIVISOR_BITS = ELAPSED_BITS - 1;
  localparam int CNT_BITS     = 6;

  localparam int IN_DATA_BITS  = FRAME_BITS + RAW_BITS + TIME_BITS;
  localparam int OUT_DATA_BITS = POS_BITS + DELTA_BITS + ELAPSED_BITS + VEL_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_MODE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CALIB       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_PERIOD = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN        = 2'd3;

  localparam logic [PERIOD_BITS-1:0] LOOP_PERIOD_RST = 16'd1000;
  localparam logic [GAIN_BITS-1:0]   GAIN_RST        = 32'h0001_0000;

  typedef struct packed {
    logic                    start;
    logic [PROD_BITS-1:0]    dividend;
    logic [DIVISOR_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic                 neg;
    logic [PROD_BITS-1:0] quotient;
  } div_rsp_t;

  // sign-extend the low ENCODER_BITS bits of a 32-bit difference
  function automatic logic [RAW_BITS-1:0] fold_enc(input logic [RAW_BITS-1:0] d);
    logic signed [RAW_BITS-1:0] sh;
    sh = $signed(d << ENC_SHIFT);
    return RAW_BITS'(sh >>> ENC_SHIFT);
  endfunction

endpackage
`default_nettype wire

@@ design/encwpv_div.sv @@
`default_nettype none
`include "encoder_wrap_position_velocity_assert.svh"
// Restoring divider, one quotient bit per cycle, sign-magnitude.
module encwpv_div (
  input  wire                  clk,
  input  wire                  rst,
  input  encwpv_pkg::div_req_t req,
  output encwpv_pkg::div_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic                                neg;
  logic [encwpv_pkg::PROD_BITS-1:0]    quo;
  logic [encwpv_pkg::DIVISOR_BITS-1:0] rem;
  logic [encwpv_pkg::CNT_BITS-1:0]     count;

  logic [encwpv_pkg::DIVISOR_BITS:0]   trial;
  logic [encwpv_pkg::DIVISOR_BITS+1:0] diff;
  logic                                fits;

  assign trial = {rem, quo[encwpv_pkg::PROD_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, req.divisor};
  assign fits  = !diff[encwpv_pkg::DIVISOR_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && count == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg   <= req.dividend[encwpv_pkg::PROD_BITS-1];
      quo   <= req.dividend[encwpv_pkg::PROD_BITS-1] ? (~req.dividend + 1'b1) : req.dividend;
      rem   <= '0;
      count <= '1;
    end else if (busy) begin
      quo   <= {quo[encwpv_pkg::PROD_BITS-2:0], fits};
      rem   <= fits ? diff[encwpv_pkg::DIVISOR_BITS-1:0] : trial[encwpv_pkg::DIVISOR_BITS-1:0];
      count <= count - 1'b1;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.neg      = neg;
  assign rsp.quotient = quo;

  `ENCWPV_ASSERT_IMPL(a_start_when_free, clk, rst, req.start, !busy)
  `ENCWPV_ASSERT_IMPL(a_done_not_busy, clk, rst, done, !busy)
  `ENCWPV_ASSERT_NEXT(a_last_step_done, clk, rst, busy && count == '0 && !req.start, done)

endmodule
`default_nettype wire

@@ design/encoder_wrap_position_velocity.sv @@
// Encoder position and velocity estimator. One sensor sample per input transfer
// (frame counter, raw encoder count, timer timestamp). The first sample after
// reset primes the position and gives no result; a sample with an unchanged
// frame counter gives none either. Other samples give one result: position,
// encoder delta, elapsed timer ticks and the Q32.16 velocity from a single
// bit-serial divider (64 steps). An item with a result is decoded, multiplied,
// starts the divider, runs through it, sees it finish and loads the output
// register before the next sample transfers; a sample with no result returns
// to idle after decoding, and one with a non-positive elapsed time skips the
// divider and gives zero velocity with m_tuser set. The result waits in an
// output register so the next sample is taken while it is held; the last step
// stalls only while the previous result has not been taken. Configuration
// writes are taken at any time, intended for idle.
`default_nettype none
`include "encoder_wrap_position_velocity_assert.svh"
module encoder_wrap_position_velocity (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    s_tvalid,
  output logic                                   s_tready,
  // frame_count, encoder_raw, sample_time
  input  wire [encwpv_pkg::IN_DATA_BITS-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  wire                                    m_tready,
  // position_ticks, delta_ticks, elapsed_ticks, velocity
  output logic [encwpv_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // bad_time
  output logic                                   m_tuser,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [encwpv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire [encwpv_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_MUL   = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic                                 wrap_mode;
  logic [encwpv_pkg::CALIB_BITS-1:0]    calib_offset;
  logic [encwpv_pkg::PERIOD_BITS-1:0]   loop_period_ticks;
  logic [encwpv_pkg::GAIN_BITS-1:0]     velocity_gain;

  logic                                 primed;
  logic [encwpv_pkg::FRAME_BITS-1:0]    last_frame;
  logic [encwpv_pkg::RAW_BITS-1:0]      last_encoder;
  logic [encwpv_pkg::TIME_BITS-1:0]     last_time;
  logic [encwpv_pkg::POS_BITS-1:0]      position_acc;

  logic [encwpv_pkg::FRAME_BITS-1:0]    in_frame;
  logic [encwpv_pkg::RAW_BITS-1:0]      in_raw;
  logic [encwpv_pkg::TIME_BITS-1:0]     in_time;

  logic [encwpv_pkg::DELTA_BITS-1:0]    delta;
  logic [encwpv_pkg::ELAPSED_BITS-1:0]  elapsed;
  logic                                 bad;
  logic [encwpv_pkg::PROD_BITS-1:0]     prod;

  logic                                 in_xfer;
  logic [encwpv_pkg::FRAME_BITS-1:0]    fdelta;
  logic [encwpv_pkg::ELAPSED_BITS-1:0]  frame_ticks;
  logic [encwpv_pkg::TIME_BITS-1:0]     tdiff;
  logic signed [encwpv_pkg::ELAPSED_BITS+1:0] elapsed_sum;
  logic [encwpv_pkg::ELAPSED_BITS-1:0]  elapsed_next;
  logic [encwpv_pkg::RAW_BITS-1:0]      raw_diff;
  logic [encwpv_pkg::RAW_BITS-1:0]      prime_diff;
  logic [encwpv_pkg::RAW_BITS-1:0]      prime_fold;
  logic [encwpv_pkg::DELTA_BITS-1:0]    delta_next;
  logic [encwpv_pkg::VEL_BITS-1:0]      vel_sat;
  logic                                 q_over_pos;
  logic                                 q_over_neg;

  encwpv_pkg::div_req_t div_req;
  encwpv_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_xfer   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_mode         <= 1'b1;
      calib_offset      <= '0;
      loop_period_ticks <= encwpv_pkg::LOOP_PERIOD_RST;
      velocity_gain     <= encwpv_pkg::GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        encwpv_pkg::REG_WRAP_MODE:   wrap_mode         <= cfg_data[0];
        encwpv_pkg::REG_CALIB:       calib_offset      <= cfg_data[encwpv_pkg::CALIB_BITS-1:0];
        encwpv_pkg::REG_LOOP_PERIOD: loop_period_ticks <= cfg_data[encwpv_pkg::PERIOD_BITS-1:0];
        encwpv_pkg::REG_GAIN:        velocity_gain     <= cfg_data[encwpv_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front-end arithmetic
  assign fdelta      = in_frame - last_frame;
  assign frame_ticks = encwpv_pkg::ELAPSED_BITS'(fdelta * loop_period_ticks);
  assign tdiff       = in_time - last_time;
  assign elapsed_sum = $signed({2'b00, frame_ticks})
                     + $signed({{(encwpv_pkg::ELAPSED_BITS+2-encwpv_pkg::TIME_BITS)
                                  {tdiff[encwpv_pkg::TIME_BITS-1]}}, tdiff});

  always_comb begin
    if (elapsed_sum > $signed({3'b000, {(encwpv_pkg::ELAPSED_BITS-1){1'b1}}})) begin
      elapsed_next = {1'b0, {(encwpv_pkg::ELAPSED_BITS-1){1'b1}}};
    end else if (elapsed_sum < $signed({3'b111, {(encwpv_pkg::ELAPSED_BITS-1){1'b0}}})) begin
      elapsed_next = {1'b1, {(encwpv_pkg::ELAPSED_BITS-1){1'b0}}};
    end else begin
      elapsed_next = elapsed_sum[encwpv_pkg::ELAPSED_BITS-1:0];
    end
  end

  assign raw_diff   = in_raw - last_encoder;
  assign prime_diff = in_raw - {{(encwpv_pkg::RAW_BITS-encwpv_pkg::CALIB_BITS){1'b0}},
                                calib_offset};
  assign prime_fold = encwpv_pkg::fold_enc(prime_diff);
  assign delta_next = wrap_mode ? encwpv_pkg::fold_enc(raw_diff) : raw_diff;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_xfer) state_next = S_PREP;
      S_PREP: begin
        if (!primed || in_frame == last_frame) state_next = S_IDLE;
        else state_next = S_MUL;
      end
      S_MUL:   state_next = bad ? S_OUT : S_START;
      S_START: state_next = S_DIV;
      S_DIV:   if (div_rsp.done) state_next = S_OUT;
      S_OUT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      primed       <= 1'b0;
      last_frame   <= '0;
      last_encoder <= '0;
      last_time    <= '0;
      position_acc <= '0;
    end else begin
      state <= state_next;
      if (state == S_PREP) begin
        if (!primed) begin
          primed       <= 1'b1;
          position_acc <= {{(encwpv_pkg::POS_BITS-encwpv_pkg::RAW_BITS)
                            {prime_fold[encwpv_pkg::RAW_BITS-1]}}, prime_fold};
          last_frame   <= in_frame;
          last_encoder <= in_raw;
          last_time    <= in_time;
        end else if (in_frame != last_frame) begin
          position_acc <= position_acc
                        + {{(encwpv_pkg::POS_BITS-encwpv_pkg::DELTA_BITS)
                            {delta_next[encwpv_pkg::DELTA_BITS-1]}}, delta_next};
          last_frame   <= in_frame;
          last_encoder <= in_raw;
          last_time    <= in_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_frame <= s_tdata[encwpv_pkg::FRAME_BITS-1:0];
      in_raw   <= s_tdata[encwpv_pkg::FRAME_BITS +: encwpv_pkg::RAW_BITS];
      in_time  <= s_tdata[encwpv_pkg::FRAME_BITS+encwpv_pkg::RAW_BITS +: encwpv_pkg::TIME_BITS];
    end
    if (state == S_PREP) begin
      delta   <= delta_next;
      elapsed <= elapsed_next;
      bad     <= elapsed_next[encwpv_pkg::ELAPSED_BITS-1] || elapsed_next == '0;
    end
    if (state == S_MUL) begin
      prod <= $signed(delta) * $signed(velocity_gain);
    end
  end

  assign div_req.start    = (state == S_START);
  assign div_req.dividend = prod;
  assign div_req.divisor  = elapsed[encwpv_pkg::DIVISOR_BITS-1:0];

  encwpv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // saturate the quotient magnitude to 48-bit signed
  assign q_over_pos = |div_rsp.quotient[encwpv_pkg::PROD_BITS-1:encwpv_pkg::VEL_BITS-1];
  assign q_over_neg = (|div_rsp.quotient[encwpv_pkg::PROD_BITS-1:encwpv_pkg::VEL_BITS])
                   || (div_rsp.quotient[encwpv_pkg::VEL_BITS-1]
                       && |div_rsp.quotient[encwpv_pkg::VEL_BITS-2:0]);

  always_comb begin
    if (bad) begin
      vel_sat = '0;
    end else if (div_rsp.neg) begin
      if (q_over_neg) vel_sat = {1'b1, {(encwpv_pkg::VEL_BITS-1){1'b0}}};
      else vel_sat = ~div_rsp.quotient[encwpv_pkg::VEL_BITS-1:0] + 1'b1;
    end else begin
      if (q_over_pos) vel_sat = {1'b0, {(encwpv_pkg::VEL_BITS-1){1'b1}}};
      else vel_sat = div_rsp.quotient[encwpv_pkg::VEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {vel_sat, elapsed, delta, position_acc};
      m_tuser <= bad;
    end
  end

  `ENCWPV_ASSERT_NEXT(a_xfer_to_prep, clk, rst, in_xfer, state == S_PREP)
  `ENCWPV_ASSERT_IMPL(a_div_only_in_div, clk, rst, div_rsp.busy,
                      state == S_DIV)
  `ENCWPV_ASSERT_IMPL(a_bad_zero_vel, clk, rst, m_tvalid && m_tuser,
                      m_tdata[encwpv_pkg::OUT_DATA_BITS-1 -: encwpv_pkg::VEL_BITS] == '0)

endmodule
`default_nettype wire
